>>> rtl/core/jst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jst_pkg
// Types, widths and action codes shared by the job slot table modules.
// ----------------------------------------------------------------------------
package jst_pkg;

	localparam int PID_W     = 31;
	localparam int JID_W     = 5;
	localparam int ST_W      = 2;
	localparam int ACT_W     = 3;
	localparam int DEPTH_DEF = 16;

	localparam logic [ACT_W-1:0] ACT_ADD = 3'd0;
	localparam logic [ACT_W-1:0] ACT_DEL = 3'd1;
	localparam logic [ACT_W-1:0] ACT_PID = 3'd2;
	localparam logic [ACT_W-1:0] ACT_JID = 3'd3;
	localparam logic [ACT_W-1:0] ACT_FG  = 3'd4;
	localparam logic [ACT_W-1:0] ACT_SET = 3'd5;

	localparam logic [ST_W-1:0] ST_FG = 2'd2;

	typedef struct packed {
		logic [PID_W-1:0] pid;
		logic [JID_W-1:0] jid;
		logic [ST_W-1:0]  st;
	} slot_t;

	typedef struct packed {
		logic take;
		logic bigger;
	} scan_t;

endpackage

>>> rtl/core/jst_slot_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jst_slot_store
// Slot memory with one registered read port, one write port and a valid
// bit per slot; a slot that is not valid reads as free.
// ----------------------------------------------------------------------------
module jst_slot_store #(
	parameter int Depth = jst_pkg::DEPTH_DEF,
	parameter int AddrW = $clog2(Depth)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [AddrW-1:0]  rd_addr,
	output jst_pkg::slot_t    rd_data,
	input  logic              wr_en,
	input  logic [AddrW-1:0]  wr_addr,
	input  jst_pkg::slot_t    wr_data,
	input  logic              clr_en,
	input  logic [AddrW-1:0]  clr_addr
);
	import jst_pkg::*;

	slot_t             mem [Depth];
	slot_t             rd_raw_q;
	logic              rd_vld_q;
	logic [Depth-1:0]  valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_raw_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= valid_q[rd_addr];
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (clr_en) begin
				valid_q[clr_addr] <= 1'b0;
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_raw_q : '0;

endmodule

>>> rtl/core/jst_match_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jst_match_unit
// Compare unit applied to one slot per cycle: decides whether the slot is
// the first target of the action and whether its job id raises the maximum.
// ----------------------------------------------------------------------------
module jst_match_unit (
	input  logic [jst_pkg::ACT_W-1:0]  action,
	input  logic [jst_pkg::PID_W-1:0]  arg_pid,
	input  logic [jst_pkg::JID_W-1:0]  arg_jid,
	input  jst_pkg::slot_t             entry,
	input  logic                       found,
	input  logic [jst_pkg::JID_W-1:0]  max_jid,
	output jst_pkg::scan_t             res
);
	import jst_pkg::*;

	logic match;
	logic busy_slot;

	assign busy_slot = (entry.pid != '0);

	always_comb begin
		case (action)
			ACT_ADD: begin
				match = !busy_slot && (arg_pid != '0);
			end
			ACT_DEL, ACT_PID, ACT_SET: begin
				match = (arg_pid != '0) && (entry.pid == arg_pid);
			end
			ACT_JID: begin
				match = (arg_jid != '0) && busy_slot && (entry.jid == arg_jid);
			end
			ACT_FG: begin
				match = busy_slot && (entry.st == ST_FG);
			end
			default: begin
				match = 1'b0;
			end
		endcase
	end

	assign res.take   = match && !found;
	assign res.bigger = !res.take && (entry.jid > max_jid);

endmodule

>>> rtl/core/job_slot_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// job_slot_table
// Table of job slots holding process id, job id and run state per slot.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_ready) carries one action per transfer:
// add, delete, lookup by process id, lookup by job id, foreground query or
// set state. Every accepted action gives exactly one result transfer on the
// output channel (out_valid, out_ready) with ok, out_pid, out_jid, out_state.
// The sequencer reads the slot memory one slot per cycle through its single
// read port and feeds each slot to one compare unit. A scan stops at the
// first target, except for delete, which reads every slot to find the
// largest job id left. The next action is taken only once the result of the
// last one is registered, so the table works on one action at a time.
// Reset empties every slot at once through per-slot valid bits and sets the
// next job id to one. A result waiting for out_ready does not block the
// next input transfer; a second result waits in the sequencer until the
// output register is free.
// ----------------------------------------------------------------------------
module job_slot_table #(
	parameter int Depth = jst_pkg::DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [jst_pkg::ACT_W-1:0]  action,
	input  logic [jst_pkg::PID_W-1:0]  pid,
	input  logic [jst_pkg::JID_W-1:0]  jid,
	input  logic [jst_pkg::ST_W-1:0]   run_state,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       ok,
	output logic [jst_pkg::PID_W-1:0]  out_pid,
	output logic [jst_pkg::JID_W-1:0]  out_jid,
	output logic [jst_pkg::ST_W-1:0]   out_state
);
	import jst_pkg::*;

	localparam int AddrW = $clog2(Depth);
	localparam int CntW  = $clog2(Depth + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t              state_q;
	logic [ACT_W-1:0]    act_q;
	logic [PID_W-1:0]    pid_q;
	logic [JID_W-1:0]    jid_q;
	logic [ST_W-1:0]     st_q;
	logic [CntW-1:0]     cnt_q;
	logic                chk_vld_s1;
	logic [AddrW-1:0]    chk_idx_s1;
	logic                hit_q;
	logic [AddrW-1:0]    hit_idx_q;
	slot_t               hit_data_q;
	logic [JID_W-1:0]    max_q;
	logic [JID_W-1:0]    next_q;
	logic                out_valid_q;
	logic                ok_q;
	slot_t               res_q;

	slot_t               rd_data;
	scan_t               scan;
	logic                cnt_live;
	logic                scan_done;
	logic                out_free;
	logic                fin_go;
	logic                wr_en;
	logic                clr_en;
	slot_t               wr_data;
	slot_t               res_d;
	logic [JID_W-1:0]    nxt_inc;
	logic [JID_W-1:0]    add_next;

	jst_slot_store #(
		.Depth (Depth),
		.AddrW (AddrW)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (cnt_q[AddrW-1:0]),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (hit_idx_q),
		.wr_data  (wr_data),
		.clr_en   (clr_en),
		.clr_addr (hit_idx_q)
	);

	jst_match_unit u_match (
		.action  (act_q),
		.arg_pid (pid_q),
		.arg_jid (jid_q),
		.entry   (rd_data),
		.found   (hit_q),
		.max_jid (max_q),
		.res     (scan)
	);

	assign cnt_live  = (cnt_q < CntW'(Depth));
	assign scan_done = chk_vld_s1 && ((scan.take && (act_q != ACT_DEL)) ||
		(chk_idx_s1 == AddrW'(Depth - 1)));
	assign out_free  = !out_valid_q || out_ready;
	assign fin_go    = (state_q == S_FIN) && out_free;
	assign in_ready  = (state_q == S_IDLE);

	assign nxt_inc  = next_q + JID_W'(1);
	assign add_next = (int'(nxt_inc) > Depth) ? JID_W'(1) : nxt_inc;

	always_comb begin
		res_d = hit_data_q;
		if (act_q == ACT_ADD) begin
			res_d = '{pid: pid_q, jid: next_q, st: st_q};
		end else if (act_q == ACT_SET) begin
			res_d.st = st_q;
		end
		if (!hit_q) begin
			res_d = '0;
		end
	end

	assign wr_data = res_d;
	assign wr_en   = fin_go && hit_q && ((act_q == ACT_ADD) || (act_q == ACT_SET));
	assign clr_en  = fin_go && hit_q && (act_q == ACT_DEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			chk_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
			max_q       <= '0;
			next_q      <= JID_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			chk_vld_s1 <= (state_q == S_SCAN) && cnt_live;
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_SCAN;
						cnt_q   <= '0;
						hit_q   <= 1'b0;
						max_q   <= '0;
					end
				end
				S_SCAN: begin
					if (cnt_live) begin
						cnt_q <= cnt_q + CntW'(1);
					end
					if (chk_vld_s1 && scan.take) begin
						hit_q <= 1'b1;
					end
					if (chk_vld_s1 && scan.bigger) begin
						max_q <= rd_data.jid;
					end
					if (scan_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (hit_q && (act_q == ACT_ADD)) begin
							next_q <= add_next;
						end else if (hit_q && (act_q == ACT_DEL)) begin
							next_q <= max_q + JID_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			act_q <= action;
			pid_q <= pid;
			jid_q <= jid;
			st_q  <= run_state;
		end
		chk_idx_s1 <= cnt_q[AddrW-1:0];
		if ((state_q == S_SCAN) && chk_vld_s1 && scan.take) begin
			hit_idx_q  <= chk_idx_s1;
			hit_data_q <= rd_data;
		end
		if (fin_go) begin
			ok_q  <= hit_q;
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign out_pid   = res_q.pid;
	assign out_jid   = res_q.jid;
	assign out_state = res_q.st;

endmodule

>>> rtl/core/jst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jst_checker
// Port-level checks on the job slot table, bound to the top level.
// ----------------------------------------------------------------------------
module jst_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       ok,
	input logic [jst_pkg::PID_W-1:0]  out_pid,
	input logic [jst_pkg::JID_W-1:0]  out_jid,
	input logic [jst_pkg::ST_W-1:0]   out_state
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pid) && $stable(ok))
		else $error("Result changed before its transfer.");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> (out_pid == '0) && (out_jid == '0) && (out_state == '0))
		else $error("Failed result carries non-zero fields.");

	a_ok_pid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ok |-> out_pid != '0)
		else $error("Successful result with process id zero.");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Input taken again straight after a transfer.");

endmodule

bind job_slot_table jst_checker u_jst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.ok        (ok),
	.out_pid   (out_pid),
	.out_jid   (out_jid),
	.out_state (out_state)
);
